@@ src/abrf_pkg.sv @@
// Shared types and constants for the alpha-blended rectangle fill block.
package abrf_pkg;

  localparam int ADDR_W = 16;
  localparam int COLOR_W = 32;
  localparam int COUNT_W = 15;
  localparam int REG_INDEX_W = 8;
  localparam int REG_DATA_W = 8;

  localparam logic [REG_INDEX_W-1:0] REG_IMG_COLS = 8'd0;
  localparam logic [REG_INDEX_W-1:0] REG_IMG_ROWS = 8'd1;
  localparam logic [REG_DATA_W-1:0] IMAGE_SIZE_RESET = 8'd128;

  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    OP_PIXEL,
    OP_READ,
    OP_DONE
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic                 inb;
    logic [ADDR_W-1:0]    addr;
    logic [COLOR_W-1:0]   color;
  } op_t;

  typedef struct packed {
    logic [COLOR_W-1:0]   read_color;
    logic [COUNT_W-1:0]   pixels_written;
  } res_t;

endpackage

@@ src/alpha_blended_rect_fill_core.sv @@
// Top level: configuration registers, command and result queues, front and back ends.
// A read item blocks the input until the front end has pushed its read operation into the
// command queue; its result passes through the back end's memory read and the result queue.
// A draw item blocks the input while the front end walks the rectangle at one pixel a cycle
// unless the command queue is full, then issues a done operation; its result follows the walk.
// Reset clears all MAX_WIDTH*MAX_HEIGHT framebuffer words with full high; sizes reset to 128.
module alpha_blended_rect_fill_core #(
  parameter int MAX_WIDTH = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                kind,
  input  logic signed [15:0]                  x_start,
  input  logic signed [15:0]                  y_start,
  input  logic [7:0]                          rect_width,
  input  logic [7:0]                          rect_height,
  input  logic [abrf_pkg::COLOR_W-1:0]        fill_color,
  output logic                                empty,
  input  logic                                pop,
  output logic [abrf_pkg::COLOR_W-1:0]        read_color,
  output logic [abrf_pkg::COUNT_W-1:0]        pixels_written,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [abrf_pkg::REG_INDEX_W-1:0]    cfg_index,
  input  logic [abrf_pkg::REG_DATA_W-1:0]     cfg_data
);
  import abrf_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  logic [REG_DATA_W-1:0] img_cols;
  logic [REG_DATA_W-1:0] img_rows;
  logic [7:0]            eff_width;
  logic [7:0]            eff_height;

  logic                  front_busy;
  logic                  clearing;
  logic                  take;
  logic                  cmd_push;
  op_t                   cmd_op;
  logic                  cmd_full;
  logic                  cmd_pop;
  op_t                   cmd_head;
  logic                  cmd_empty;
  logic                  res_push;
  res_t                  res_in;
  res_t                  res_out;
  logic                  res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_cols <= IMAGE_SIZE_RESET;
      img_rows <= IMAGE_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_IMG_COLS) begin
        img_cols <= cfg_data;
      end else if (cfg_index == REG_IMG_ROWS) begin
        img_rows <= cfg_data;
      end
    end
  end

  assign eff_width = ({5'b0, img_cols} > 13'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : img_cols;
  assign eff_height = ({5'b0, img_rows} > 13'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : img_rows;

  assign full = front_busy || clearing;
  assign take = push && !full;

  abrf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .kind        (kind),
    .x_start     (x_start),
    .y_start     (y_start),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .fill_color  (fill_color),
    .eff_width   (eff_width),
    .eff_height  (eff_height),
    .busy        (front_busy),
    .cmd_push    (cmd_push),
    .cmd_op      (cmd_op),
    .cmd_full    (cmd_full)
  );

  abrf_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (4)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_op),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty)
  );

  abrf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_head  (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_in),
    .res_full  (res_full),
    .clearing  (clearing)
  );

  abrf_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign read_color = res_out.read_color;
  assign pixels_written = res_out.pixels_written;

endmodule

@@ src/abrf_fifo.sv @@
// Small register-based first-in first-out queue.
module abrf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

@@ src/abrf_front.sv @@
// Front end: accepts items, walks draw rectangles and issues pixel, read and done operations.
module abrf_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic                       kind,
  input  logic signed [15:0]         x_start,
  input  logic signed [15:0]         y_start,
  input  logic [7:0]                 rect_width,
  input  logic [7:0]                 rect_height,
  input  logic [abrf_pkg::COLOR_W-1:0] fill_color,
  input  logic [7:0]                 eff_width,
  input  logic [7:0]                 eff_height,
  output logic                       busy,
  output logic                       cmd_push,
  output abrf_pkg::op_t              cmd_op,
  input  logic                       cmd_full
);
  import abrf_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_WALK,
    F_DONE
  } fstate_t;

  fstate_t              state;
  logic signed [15:0]   x0;
  logic signed [15:0]   y0;
  logic [7:0]           rw;
  logic [7:0]           rh;
  logic [COLOR_W-1:0]   color;
  logic [7:0]           col;
  logic [7:0]           row;

  logic [16:0]          x_pos;
  logic [16:0]          y_pos;
  logic                 inb;
  logic [ADDR_W-1:0]    addr;
  logic                 advance;

  always_comb begin
    x_pos = {x0[15], x0} + {9'b0, col};
    y_pos = {y0[15], y0} + {9'b0, row};
    inb = !x_pos[16] && !y_pos[16] &&
          (x_pos[15:0] < {8'b0, eff_width}) && (y_pos[15:0] < {8'b0, eff_height});
    addr = 16'(eff_width * y_pos[7:0]) + {8'b0, x_pos[7:0]};
  end

  always_comb begin
    cmd_push = 1'b0;
    cmd_op = '{kind: OP_PIXEL, inb: inb, addr: addr, color: color};
    advance = 1'b0;
    case (state)
      F_READ: begin
        cmd_op.kind = OP_READ;
        cmd_push = !cmd_full;
      end
      F_WALK: begin
        cmd_push = inb && !cmd_full;
        advance = !inb || !cmd_full;
      end
      F_DONE: begin
        cmd_op.kind = OP_DONE;
        cmd_push = !cmd_full;
      end
      default: begin
        cmd_push = 1'b0;
      end
    endcase
  end

  assign busy = (state != F_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      col <= '0;
      row <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (take) begin
            x0 <= x_start;
            y0 <= y_start;
            rw <= rect_width;
            rh <= rect_height;
            color <= fill_color;
            col <= '0;
            row <= '0;
            if (kind == KIND_READ) begin
              state <= F_READ;
            end else if (rect_width == '0 || rect_height == '0) begin
              state <= F_DONE;
            end else begin
              state <= F_WALK;
            end
          end
        end
        F_READ: begin
          if (!cmd_full) begin
            state <= F_IDLE;
          end
        end
        F_WALK: begin
          if (advance) begin
            if (col == rw - 8'd1) begin
              col <= '0;
              if (row == rh - 8'd1) begin
                state <= F_DONE;
              end else begin
                row <= row + 8'd1;
              end
            end else begin
              col <= col + 8'd1;
            end
          end
        end
        F_DONE: begin
          if (!cmd_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/abrf_back.sv @@
// Back end: framebuffer memory, clearing pass and the blend pipeline.
module abrf_back #(
  parameter int DEPTH = 16384
) (
  input  logic                clk,
  input  logic                rst,
  input  abrf_pkg::op_t       cmd_head,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  output logic                res_push,
  output abrf_pkg::res_t      res_data,
  input  logic                res_full,
  output logic                clearing
);
  import abrf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [15:0] blend_sum(input logic [7:0] fg, input logic [7:0] bg,
                                            input logic [7:0] a);
    blend_sum = 16'(16'(a) * 16'(fg)) + 16'(16'(8'd255 - a) * 16'(bg));
  endfunction

  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + {9'b0, v[15:8]} + 17'd1;
    div255 = t[15:8];
  endfunction

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic               we;
  logic [AW-1:0]      wa;
  logic [COLOR_W-1:0] wd;

  logic [AW-1:0]      clr_addr;
  logic [COUNT_W-1:0] px_count;

  logic               b_valid;
  op_kind_t           b_kind;
  logic               b_inb;
  logic [AW-1:0]      b_addr;
  logic [COLOR_W-1:0] b_color;
  logic [COUNT_W-1:0] b_count;

  logic               c_valid;
  logic [AW-1:0]      c_addr;
  logic [15:0]        c_sum [3];

  logic               pipe_free;

  assign pipe_free = !b_valid && !c_valid && !res_full;
  assign rd_addr = AW'(cmd_head.addr);

  always_comb begin
    cmd_pop = 1'b0;
    if (!cmd_empty && !clearing) begin
      case (cmd_head.kind)
        OP_PIXEL: cmd_pop = 1'b1;
        OP_READ:  cmd_pop = pipe_free;
        OP_DONE:  cmd_pop = pipe_free;
        default:  cmd_pop = 1'b1;
      endcase
    end
  end

  always_comb begin
    res_push = b_valid && (b_kind != OP_PIXEL);
    res_data.read_color = (b_kind == OP_READ && b_inb) ? rd_data : '0;
    res_data.pixels_written = (b_kind == OP_DONE) ? b_count : '0;
  end

  always_comb begin
    we = clearing || c_valid;
    wa = clearing ? clr_addr : c_addr;
    wd = clearing ? '0 : {div255(c_sum[0]), div255(c_sum[1]), div255(c_sum[2]), 8'hff};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      px_count <= '0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + 1'b1;
      end
      b_valid <= cmd_pop && (cmd_head.kind != OP_PIXEL || cmd_head.inb);
      c_valid <= b_valid && (b_kind == OP_PIXEL);
      if (cmd_pop && cmd_head.kind == OP_PIXEL) begin
        px_count <= px_count + 1'b1;
      end else if (cmd_pop && cmd_head.kind == OP_DONE) begin
        px_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_kind <= cmd_head.kind;
    b_inb <= cmd_head.inb;
    b_addr <= rd_addr;
    b_color <= cmd_head.color;
    b_count <= px_count;
    c_addr <= b_addr;
    c_sum[0] <= blend_sum(b_color[31:24], rd_data[31:24], b_color[7:0]);
    c_sum[1] <= blend_sum(b_color[23:16], rd_data[23:16], b_color[7:0]);
    c_sum[2] <= blend_sum(b_color[15:8], rd_data[15:8], b_color[7:0]);
  end

endmodule

@@ sim/alpha_blended_rect_fill_core_test.sv @@
// Self-checking testbench for the alpha-blended rectangle fill core with directed and random traffic.
`timescale 1ns / 100ps

module alpha_blended_rect_fill_core_test;
  import abrf_pkg::*;

  localparam int FB_W = 128;
  localparam int FB_H = 128;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLDOFF_CYCLES = 1500;
  localparam int RANDOM_PER_PHASE = 120;
  localparam int MAX_REPORTED = 10;
  localparam logic [REG_INDEX_W-1:0] REG_UNUSED_LOW = 8'd2;
  localparam logic [REG_INDEX_W-1:0] REG_UNUSED_HIGH = 8'hff;

  typedef struct {
    logic              kind;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [7:0]         wid;
    logic [7:0]         hgt;
    logic [COLOR_W-1:0] color;
  } pixel_cmd_t;

  typedef enum {
    POP_ALWAYS,
    POP_HALF,
    POP_SPARSE
  } pop_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic kind = KIND_DRAW;
  logic signed [15:0] x_start = '0;
  logic signed [15:0] y_start = '0;
  logic [7:0] rect_width = '0;
  logic [7:0] rect_height = '0;
  logic [COLOR_W-1:0] fill_color = '0;
  logic empty;
  logic pop = 1'b0;
  logic [COLOR_W-1:0] read_color;
  logic [COUNT_W-1:0] pixels_written;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_INDEX_W-1:0] cfg_index = '0;
  logic [REG_DATA_W-1:0] cfg_data = '0;

  logic [COLOR_W-1:0] canvas [0:FB_W*FB_H-1];
  int img_w;
  int img_h;
  pixel_cmd_t pending_cmds[$];
  res_t pixel_reports[$];
  pixel_cmd_t cur_cmd;
  int cmds_queued = 0;
  int cmds_accepted = 0;
  int reports_seen = 0;
  int mismatch_count = 0;
  int burst_left;
  int gap_left;
  int holdoff_left;
  int mode_left;
  pop_mode_t pop_mode;

  alpha_blended_rect_fill_core #(
    .MAX_WIDTH(FB_W),
    .MAX_HEIGHT(FB_H)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .kind(kind),
    .x_start(x_start),
    .y_start(y_start),
    .rect_width(rect_width),
    .rect_height(rect_height),
    .fill_color(fill_color),
    .empty(empty),
    .pop(pop),
    .read_color(read_color),
    .pixels_written(pixels_written),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #400_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [COLOR_W-1:0] blend_pixel(input logic [COLOR_W-1:0] fg,
                                                     input logic [COLOR_W-1:0] bg);
    int a;
    int k;
    int mixed;
    logic [COLOR_W-1:0] out;
    a = int'(fg[7:0]);
    out = '0;
    for (k = 1; k < 4; k++) begin
      mixed = (a * int'(fg[8*k +: 8]) + (255 - a) * int'(bg[8*k +: 8])) / 255;
      out[8*k +: 8] = mixed[7:0];
    end
    out[7:0] = 8'hff;
    return out;
  endfunction

  task automatic render_cmd(input pixel_cmd_t c);
    int ew;
    int eh;
    int x;
    int y;
    int i;
    int j;
    int cnt;
    res_t rep;
    ew = (img_w > FB_W) ? FB_W : img_w;
    eh = (img_h > FB_H) ? FB_H : img_h;
    cnt = 0;
    rep.read_color = '0;
    if (c.kind == KIND_READ) begin
      x = c.x_pos;
      y = c.y_pos;
      if (x >= 0 && y >= 0 && x < ew && y < eh) begin
        rep.read_color = canvas[ew * y + x];
      end
    end else begin
      for (j = 0; j < int'(c.hgt); j++) begin
        for (i = 0; i < int'(c.wid); i++) begin
          x = int'(c.x_pos) + i;
          y = int'(c.y_pos) + j;
          if (x >= 0 && y >= 0 && x < ew && y < eh) begin
            canvas[ew * y + x] = blend_pixel(c.color, canvas[ew * y + x]);
            cnt++;
          end
        end
      end
    end
    rep.pixels_written = cnt[COUNT_W-1:0];
    pixel_reports.push_back(rep);
  endtask

  function automatic pixel_cmd_t make_cmd(input logic k, input int x, input int y,
                                          input int w, input int h, input logic [31:0] color);
    pixel_cmd_t c;
    c.kind = k;
    c.x_pos = x[15:0];
    c.y_pos = y[15:0];
    c.wid = w[7:0];
    c.hgt = h[7:0];
    c.color = color;
    return c;
  endfunction

  function automatic int pick_coord(input int extent);
    int e;
    e = (extent > FB_W) ? FB_W : extent;
    if ($urandom_range(0, 99) < 10) begin
      return int'($urandom_range(0, 65535)) - 32768;
    end
    return int'($urandom_range(0, e + 24)) - 16;
  endfunction

  function automatic pixel_cmd_t random_cmd();
    pixel_cmd_t c;
    int sel;
    c.kind = ($urandom_range(0, 99) < 45) ? KIND_READ : KIND_DRAW;
    c.x_pos = 16'(pick_coord(img_w));
    c.y_pos = 16'(pick_coord(img_h));
    c.color = $urandom;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      c.color[7:0] = 8'hff;
    end else if (sel == 2) begin
      c.color[7:0] = 8'h00;
    end
    sel = $urandom_range(0, 99);
    if (sel < 77) begin
      c.wid = 8'($urandom_range(0, 8));
      c.hgt = 8'($urandom_range(0, 8));
    end else if (sel < 92) begin
      c.wid = 8'($urandom_range(0, 40));
      c.hgt = 8'($urandom_range(0, 40));
    end else if (sel < 96) begin
      c.wid = 8'($urandom_range(0, 255));
      c.hgt = 8'($urandom_range(0, 3));
    end else begin
      c.wid = 8'($urandom_range(0, 3));
      c.hgt = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  task automatic queue_cmd(input pixel_cmd_t c);
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  task automatic wait_drained();
    while (cmds_accepted != cmds_queued || pixel_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_INDEX_W-1:0] idx,
                           input logic [REG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_IMG_COLS) begin
      img_w = int'(val);
    end else if (idx == REG_IMG_ROWS) begin
      img_h = int'(val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (push && !full) begin
        render_cmd(cur_cmd);
        cmds_accepted++;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          kind <= cur_cmd.kind;
          x_start <= cur_cmd.x_pos;
          y_start <= cur_cmd.y_pos;
          rect_width <= cur_cmd.wid;
          rect_height <= cur_cmd.hgt;
          fill_color <= cur_cmd.color;
          push <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      pop <= 1'b0;
      holdoff_left = 0;
      mode_left = 0;
      pop_mode = POP_ALWAYS;
    end else begin
      if (pop && !empty) begin
        if (pixel_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED) begin
            $display("Unexpected result: read_color=%h pixels_written=%0d",
                     read_color, pixels_written);
          end
        end else begin
          want = pixel_reports.pop_front();
          if (read_color !== want.read_color || pixels_written !== want.pixels_written) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED) begin
              $display("Mismatch on result %0d: expected read_color=%h pixels_written=%0d,",
                       reports_seen, want.read_color, want.pixels_written,
                       " got read_color=%h pixels_written=%0d",
                       read_color, pixels_written);
            end
          end
        end
        reports_seen++;
        if (reports_seen == 300 || reports_seen == 800) begin
          holdoff_left = HOLDOFF_CYCLES;
        end
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        pop <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          pop_mode = pop_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 200);
        end else begin
          mode_left--;
        end
        case (pop_mode)
          POP_ALWAYS: begin
            pop <= 1'b1;
          end
          POP_HALF: begin
            pop <= 1'($urandom_range(0, 1));
          end
          default: begin
            pop <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  initial begin
    int phase_w[] = '{1, 0, 255, 37, 128, 64, 200, 128};
    int phase_h[] = '{1, 64, 200, 19, 0, 128, 3, 128};
    int p;
    int n;
    for (n = 0; n < FB_W * FB_H; n++) begin
      canvas[n] = '0;
    end
    img_w = int'(IMAGE_SIZE_RESET);
    img_h = int'(IMAGE_SIZE_RESET);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    queue_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 32'h0));
    queue_cmd(make_cmd(KIND_DRAW, 0, 0, 255, 255, 32'h204060ff));
    queue_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 32'h0));
    queue_cmd(make_cmd(KIND_READ, 127, 127, 0, 0, 32'h0));
    queue_cmd(make_cmd(KIND_DRAW, -5, -5, 10, 10, 32'hff804080));
    queue_cmd(make_cmd(KIND_READ, 4, 4, 0, 0, 32'h0));
    queue_cmd(make_cmd(KIND_READ, 5, 5, 0, 0, 32'h0));
    queue_cmd(make_cmd(KIND_DRAW, 10, 10, 4, 4, 32'hffffff00));
    queue_cmd(make_cmd(KIND_READ, 11, 11, 0, 0, 32'h0));
    queue_cmd(make_cmd(KIND_DRAW, 0, 0, 0, 3, 32'hffffffff));
    queue_cmd(make_cmd(KIND_DRAW, 0, 0, 3, 0, 32'hffffffff));
    queue_cmd(make_cmd(KIND_DRAW, -32768, -32768, 3, 3, 32'hffffffff));
    queue_cmd(make_cmd(KIND_DRAW, 32767, 32767, 255, 1, 32'hffffffff));
    queue_cmd(make_cmd(KIND_DRAW, 120, 125, 255, 3, 32'h00000000));
    queue_cmd(make_cmd(KIND_DRAW, 126, 0, 2, 2, 32'hffffffff));
    queue_cmd(make_cmd(KIND_READ, -1, 0, 0, 0, 32'h0));
    queue_cmd(make_cmd(KIND_READ, 128, 5, 0, 0, 32'h0));
    queue_cmd(make_cmd(KIND_READ, 5, 128, 0, 0, 32'h0));
    queue_cmd(make_cmd(KIND_READ, -32768, 32767, 0, 0, 32'h0));
    queue_cmd(make_cmd(KIND_READ, 32767, -32768, 0, 0, 32'h0));
    queue_cmd(make_cmd(KIND_READ, 127, 0, 0, 0, 32'h0));
    queue_cmd(make_cmd(KIND_READ, 121, 126, 0, 0, 32'h0));
    queue_cmd(make_cmd(KIND_DRAW, 60, 60, 1, 1, 32'h00000080));
    queue_cmd(make_cmd(KIND_READ, 60, 60, 0, 0, 32'h0));
    wait_drained();

    for (p = 0; p <= phase_w.size(); p++) begin
      if (p < phase_w.size()) begin
        write_reg(REG_IMG_COLS, 8'(phase_w[p]));
        write_reg(REG_IMG_ROWS, 8'(phase_h[p]));
      end else begin
        write_reg(REG_IMG_COLS, 8'($urandom_range(1, 160)));
        write_reg(REG_IMG_ROWS, 8'($urandom_range(1, 160)));
      end
      if (p == 0) begin
        write_reg(REG_UNUSED_LOW, 8'h55);
        write_reg(REG_UNUSED_HIGH, 8'haa);
      end
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        queue_cmd(random_cmd());
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/abrf_pkg.sv
src/abrf_fifo.sv
src/abrf_front.sv
src/abrf_back.sv
src/alpha_blended_rect_fill_core.sv
sim/alpha_blended_rect_fill_core_test.sv
